[sv/rsc_pkg.sv]
// Shared types and codes for the sequenced relay command handler.
`timescale 1ns / 1ps

package rsc_pkg;

	localparam int LANES = 4;

	localparam logic [2:0] OP_ACK   = 3'd0;
	localparam logic [2:0] OP_RELAY = 3'd1;
	localparam logic [2:0] OP_STATE = 3'd2;
	localparam logic [2:0] OP_QUIT  = 3'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SEQ     = 3'd1;
	localparam logic [2:0] ST_RANGE   = 3'd2;
	localparam logic [2:0] ST_CLOSE   = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_RPT  = 2'd1;
	localparam logic [1:0] KIND_FIN  = 2'd2;

	localparam logic REG_RELAY_COUNT = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_EMIT_ACK,
		S_EMIT_RPT,
		S_EMIT_FIN
	} state_t;

	// What one lane found out about its relay setting.
	typedef struct packed {
		logic bad;
		logic on;
	} lane_res_t;

endpackage

[sv/rsc_lane.sv]
// One checking lane: validates a single relay setting and decodes its target relay.
`timescale 1ns / 1ps

module rsc_lane #(
	parameter int NUM_RELAYS = 4
) (
	input  logic [7:0]            idx,
	input  logic [7:0]            val,
	input  logic [2:0]            used,
	output logic [NUM_RELAYS-1:0] hit,
	output rsc_pkg::lane_res_t    res
);
	import rsc_pkg::*;

	always_comb begin
		for (int j = 0; j < NUM_RELAYS; j++) begin
			hit[j] = (idx == 8'(j));
		end
		res.bad = (idx >= {5'b0, used}) || (val > 8'd1);
		res.on  = val[0];
	end

endmodule

[sv/rsc_merge.sv]
// Merging stage: applies the lane results in packet order and stops at the first bad setting.
`timescale 1ns / 1ps

module rsc_merge #(
	parameter int NUM_RELAYS = 4
) (
	input  logic [7:0]                 count,
	input  logic [2:0]                 used,
	input  rsc_pkg::lane_res_t         lane_res [rsc_pkg::LANES],
	input  logic [NUM_RELAYS-1:0]      lane_hit [rsc_pkg::LANES],
	input  logic [NUM_RELAYS-1:0]      relay_cur,
	output logic [NUM_RELAYS-1:0]      relay_next,
	output logic                       range_err
);
	import rsc_pkg::*;

	logic stop;

	always_comb begin
		relay_next = relay_cur;
		range_err  = 1'b0;
		stop       = 1'b0;
		if (count == 8'd0 || count > {5'b0, used}) begin
			range_err = 1'b1;
		end else begin
			for (int i = 0; i < LANES; i++) begin
				if (!stop && 8'(i) < count) begin
					if (lane_res[i].bad) begin
						range_err = 1'b1;
						stop      = 1'b1;
					end else begin
						relay_next = (relay_next & ~lane_hit[i]) |
							(lane_hit[i] & {NUM_RELAYS{lane_res[i].on}});
					end
				end
			end
		end
	end

endmodule

[sv/sequenced_relay_command_handler.sv]
// Top level of the sequenced relay command handler: sequencer, state and output register.
`timescale 1ns / 1ps

// Takes one command packet at a time and answers with one to three result items, the last
// of which is a final status marked by m_tlast. An item is registered on acceptance,
// checked in the next cycle (sequence numbers and, for a relay set, the four settings in
// parallel lanes), and then its results leave one per cycle, as long as the sink is ready,
// through a single output register. The next item is accepted once the final status has
// been loaded into the output register. relay_count is written through the APB port at
// address 0 and should only be changed while no item is in flight.
module sequenced_relay_command_handler #(
	parameter int NUM_RELAYS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// seq_num[31:0], settings_count[39:32], relay_index_a[47:40], relay_value_a[55:48],
	// relay_index_b[63:56], relay_value_b[71:64], relay_index_c[79:72],
	// relay_value_c[87:80], relay_index_d[95:88], relay_value_d[103:96]
	input  logic [103:0] s_tdata,
	// op[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// seq_out[31:0], relay_bitmap[35:32], status[38:36], zero[39]
	output logic [39:0]  m_tdata,
	// kind[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import rsc_pkg::*;

	state_t state_q, state_d;

	logic [2:0]  relay_count_q;
	logic [31:0] rx_last_seq_q;
	logic [31:0] tx_seq_q;
	logic [NUM_RELAYS-1:0] relay_on_q;

	logic [2:0]  op_q;
	logic [31:0] seq_q;
	logic [7:0]  cnt_q;
	logic [7:0]  idx_q [LANES];
	logic [7:0]  val_q [LANES];

	logic [31:0] ack_seq_q;
	logic [31:0] rpt_seq_q;
	logic [3:0]  bitmap_q;
	logic [2:0]  status_q;
	logic        has_rpt_q;

	logic        m_tvalid_q;
	logic [31:0] m_seq_q;
	logic [3:0]  m_bitmap_q;
	logic [2:0]  m_status_q;
	logic [1:0]  m_kind_q;
	logic        m_last_q;

	logic [2:0]  used;
	logic [31:0] tx_inc;
	logic        is_ack;
	logic        seq_ok;
	logic        chk_has_ack;
	logic [3:0]  bitmap_now;

	lane_res_t             lane_res [LANES];
	logic [NUM_RELAYS-1:0] lane_hit [LANES];
	logic [NUM_RELAYS-1:0] relay_next;
	logic                  range_err;

	logic        in_fire;
	logic        out_free;
	logic        load_out;
	logic        do_check;
	logic [1:0]  out_kind;
	logic [31:0] out_seq;
	logic [3:0]  out_bitmap;
	logic [2:0]  out_status;
	logic        out_last;
	logic        cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_RELAY_COUNT) ? {29'b0, relay_count_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_count_q <= 3'd2;
		end else if (cfg_wr && paddr[2] == REG_RELAY_COUNT) begin
			relay_count_q <= pwdata[2:0];
		end
	end

	assign used = (relay_count_q > 3'(NUM_RELAYS)) ? 3'(NUM_RELAYS) : relay_count_q;

	// Setting lanes and merge.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		rsc_lane #(.NUM_RELAYS(NUM_RELAYS)) u_lane (
			.idx  (idx_q[g]),
			.val  (val_q[g]),
			.used (used),
			.hit  (lane_hit[g]),
			.res  (lane_res[g])
		);
	end

	rsc_merge #(.NUM_RELAYS(NUM_RELAYS)) u_merge (
		.count      (cnt_q),
		.used       (used),
		.lane_res   (lane_res),
		.lane_hit   (lane_hit),
		.relay_cur  (relay_on_q),
		.relay_next (relay_next),
		.range_err  (range_err)
	);

	// Sequence checks of the registered item.
	assign tx_inc      = tx_seq_q + 32'd1;
	assign is_ack      = (op_q == OP_ACK);
	assign seq_ok      = (seq_q == rx_last_seq_q + 32'd1) && (seq_q != 32'd0);
	assign chk_has_ack = !is_ack && seq_ok;

	always_comb begin
		bitmap_now = '0;
		for (int j = 0; j < NUM_RELAYS; j++) begin
			bitmap_now[j] = relay_on_q[j] && (3'(j) < used);
		end
	end

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = chk_has_ack ? S_EMIT_ACK : S_EMIT_FIN;
			end
			S_EMIT_ACK: begin
				if (out_free) state_d = has_rpt_q ? S_EMIT_RPT : S_EMIT_FIN;
			end
			S_EMIT_RPT: begin
				if (out_free) state_d = S_EMIT_FIN;
			end
			S_EMIT_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready   = 1'b0;
		do_check   = 1'b0;
		load_out   = 1'b0;
		out_kind   = KIND_FIN;
		out_seq    = 32'd0;
		out_bitmap = 4'd0;
		out_status = ST_OK;
		out_last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_CHECK: begin
				do_check = 1'b1;
			end
			S_EMIT_ACK: begin
				load_out = out_free;
				out_kind = KIND_ACK;
				out_seq  = ack_seq_q;
			end
			S_EMIT_RPT: begin
				load_out   = out_free;
				out_kind   = KIND_RPT;
				out_seq    = rpt_seq_q;
				out_bitmap = bitmap_q;
			end
			S_EMIT_FIN: begin
				load_out   = out_free;
				out_kind   = KIND_FIN;
				out_status = status_q;
				out_last   = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Input item capture.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_tuser;
			seq_q <= s_tdata[31:0];
			cnt_q <= s_tdata[39:32];
			for (int i = 0; i < LANES; i++) begin
				idx_q[i] <= s_tdata[40 + 16*i +: 8];
				val_q[i] <= s_tdata[48 + 16*i +: 8];
			end
		end
	end

	// Handler state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_last_seq_q <= 32'd0;
			tx_seq_q      <= 32'd0;
			relay_on_q    <= '0;
		end else if (do_check) begin
			if (is_ack) begin
				tx_seq_q <= tx_inc;
			end else if (seq_ok) begin
				rx_last_seq_q <= seq_q;
				if (op_q == OP_RELAY) relay_on_q <= relay_next;
				if (op_q == OP_STATE) tx_seq_q <= tx_inc;
			end
		end
	end

	// Results of the check, held while they are sent.
	always_ff @(posedge clk) begin
		if (do_check) begin
			ack_seq_q <= seq_q + 32'd1;
			rpt_seq_q <= tx_inc;
			bitmap_q  <= bitmap_now;
			has_rpt_q <= 1'b0;
			if (is_ack) begin
				status_q <= (seq_q == tx_inc && seq_q != 32'd0) ? ST_OK : ST_SEQ;
			end else if (!seq_ok) begin
				status_q <= ST_SEQ;
			end else begin
				unique case (op_q)
					OP_RELAY: status_q <= range_err ? ST_RANGE : ST_OK;
					OP_STATE: begin
						status_q  <= ST_OK;
						has_rpt_q <= 1'b1;
					end
					OP_QUIT:  status_q <= ST_CLOSE;
					default:  status_q <= ST_UNKNOWN;
				endcase
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_kind_q   <= out_kind;
			m_seq_q    <= out_seq;
			m_bitmap_q <= out_bitmap;
			m_status_q <= out_status;
			m_last_q   <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_status_q, m_bitmap_q, m_seq_q};
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule

[bench/relay_cmd_checker.sv]
// Checker for the relay command handler: predicts results per command and compares them.
`timescale 1ns / 1ps

module relay_cmd_checker #(
	parameter int NUM_RELAYS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         pready,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output int           fail_count,
	output int           outstanding
);
	import rsc_pkg::*;

	localparam logic [2:0] RELAY_COUNT_ADDR = {REG_RELAY_COUNT, 2'b00};

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic [3:0]  bitmap;
		logic [2:0]  status;
		logic        last;
	} relay_result_t;

	relay_result_t             pending_q[$];
	relay_result_t             want;
	logic [2:0]                relay_count;
	logic [31:0]               rx_last_seq;
	logic [31:0]               tx_seq;
	logic [NUM_RELAYS-1:0]     relay_on;

	function automatic relay_result_t make_result(input logic [1:0] kind,
			input logic [31:0] seq, input logic [3:0] bitmap, input logic [2:0] status,
			input logic last);
		relay_result_t r;
		r.kind = kind;
		r.seq = seq;
		r.bitmap = bitmap;
		r.status = status;
		r.last = last;
		return r;
	endfunction

	task automatic predict_command(input logic [2:0] op, input logic [103:0] d);
		logic [31:0] seq;
		logic [7:0]  cnt;
		logic [7:0]  idx;
		logic [7:0]  val;
		logic [2:0]  fin;
		logic [3:0]  map;
		logic        stop;
		int          used;
		int          i;
		seq = d[31:0];
		cnt = d[39:32];
		used = (relay_count > NUM_RELAYS) ? NUM_RELAYS : relay_count;
		if (op == OP_ACK) begin
			// The transmit counter moves even when the acknowledge turns out wrong.
			tx_seq = tx_seq + 32'd1;
			fin = (seq == tx_seq && seq != 32'd0) ? ST_OK : ST_SEQ;
			pending_q.push_back(make_result(KIND_FIN, 32'd0, 4'd0, fin, 1'b1));
		end else if (seq != rx_last_seq + 32'd1 || seq == 32'd0) begin
			pending_q.push_back(make_result(KIND_FIN, 32'd0, 4'd0, ST_SEQ, 1'b1));
		end else begin
			rx_last_seq = seq;
			pending_q.push_back(make_result(KIND_ACK, seq + 32'd1, 4'd0, ST_OK, 1'b0));
			case (op)
				OP_RELAY: begin
					fin = ST_OK;
					if (cnt < 8'd1 || cnt > used) begin
						fin = ST_RANGE;
					end else begin
						// Settings before the first bad one stay applied.
						stop = 1'b0;
						for (i = 0; i < cnt; i++) begin
							idx = d[40 + 16*i +: 8];
							val = d[48 + 16*i +: 8];
							if (!stop) begin
								if (idx >= used || val > 8'd1) begin
									stop = 1'b1;
									fin = ST_RANGE;
								end else begin
									relay_on[idx[1:0]] = val[0];
								end
							end
						end
					end
				end
				OP_STATE: begin
					map = 4'd0;
					for (i = 0; i < used; i++)
						map[i] = relay_on[i];
					tx_seq = tx_seq + 32'd1;
					pending_q.push_back(make_result(KIND_RPT, tx_seq, map, ST_OK, 1'b0));
					fin = ST_OK;
				end
				OP_QUIT: fin = ST_CLOSE;
				default: fin = ST_UNKNOWN;
			endcase
			pending_q.push_back(make_result(KIND_FIN, 32'd0, 4'd0, fin, 1'b1));
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_count = 3'd2;
			rx_last_seq = 32'd0;
			tx_seq = 32'd0;
			relay_on = '0;
			pending_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result item, expected none actual %h/%h/%b",
						$time, m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = pending_q.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("seq_out", want.seq, m_tdata[31:0]);
					check_field("relay_bitmap", want.bitmap, m_tdata[35:32]);
					check_field("status", want.status, m_tdata[38:36]);
					check_field("pad", 32'd0, m_tdata[39]);
					check_field("last", want.last, m_tlast);
				end
			end
			if (psel && penable && pwrite && pready && paddr == RELAY_COUNT_ADDR)
				relay_count = pwdata[2:0];
			if (s_tvalid && s_tready)
				predict_command(s_tuser, s_tdata);
			outstanding = pending_q.size();
		end
	end

endmodule

[bench/sequenced_relay_command_handler_tb.sv]
// Testbench top for the relay command handler: stimulus, sink pattern and verdict.
`timescale 1ns / 1ps

module sequenced_relay_command_handler_tb;
	import rsc_pkg::*;

	localparam int NUM_RELAYS = 4;
	localparam logic [2:0] OP_MAX = 3'd7;
	localparam logic [2:0] RELAY_COUNT_ADDR = {REG_RELAY_COUNT, 2'b00};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	int           fail_count;
	int           outstanding;
	int           burst_left = 0;
	bit           hold_req = 1'b0;
	logic [31:0]  rx_last = 32'd0;
	logic [31:0]  tx_count = 32'd0;
	logic [2:0]   relay_cfg = 3'd2;

	sequenced_relay_command_handler #(.NUM_RELAYS(NUM_RELAYS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	relay_cmd_checker #(.NUM_RELAYS(NUM_RELAYS)) cmd_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
		.pwdata(pwdata), .fail_count(fail_count), .outstanding(outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [15:0] setting(input logic [7:0] idx, input logic [7:0] val);
		return {val, idx};
	endfunction

	// Offers one command and returns right after the edge that accepted it.
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] seq,
			input logic [7:0] cnt, input logic [63:0] lanes);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {lanes, cnt, seq};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		if (op == OP_ACK) begin
			tx_count = tx_count + 32'd1;
		end else if (seq == rx_last + 32'd1 && seq != 32'd0) begin
			rx_last = seq;
			if (op == OP_STATE)
				tx_count = tx_count + 32'd1;
		end
	endtask

	// Mostly well-formed commands with random content, some stale or bogus ones.
	task automatic send_random();
		logic [2:0]  op;
		logic [31:0] seq;
		logic [7:0]  cnt;
		logic [63:0] lanes;
		int          eff;
		int          pick;
		int          i;
		eff = (relay_cfg > NUM_RELAYS) ? NUM_RELAYS : relay_cfg;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			op = OP_ACK;
		else if (pick < 60)
			op = OP_RELAY;
		else if (pick < 78)
			op = OP_STATE;
		else if (pick < 88)
			op = OP_QUIT;
		else
			op = 3'($urandom_range(OP_QUIT + 1, OP_MAX));
		seq = (op == OP_ACK) ? tx_count + 32'd1 : rx_last + 32'd1;
		pick = $urandom_range(0, 99);
		if (pick >= 95)
			seq = $urandom;
		else if (pick >= 90)
			seq = seq - 32'd1;
		else if (pick >= 86)
			seq = seq + 32'd1;
		if (op == OP_RELAY) begin
			cnt = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, (eff == 0) ? LANES : eff))
				: 8'($urandom_range(0, 255));
			for (i = 0; i < LANES; i++) begin
				pick = $urandom_range(0, 19);
				if (pick < 17)
					lanes[16*i +: 8] = 8'($urandom_range(0, (eff > 0) ? eff - 1 : 0));
				else if (pick < 18)
					lanes[16*i +: 8] = 8'(eff);
				else
					lanes[16*i +: 8] = 8'($urandom_range(0, 255));
				lanes[16*i + 8 +: 8] = ($urandom_range(0, 19) < 18) ? 8'($urandom_range(0, 1))
					: 8'($urandom_range(0, 255));
			end
		end else begin
			cnt = 8'($urandom_range(0, 255));
			lanes = {$urandom, $urandom};
		end
		send_cmd(op, seq, cnt, lanes);
	endtask

	// Waits until every result has come out, then lets the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_relay_count(input logic [2:0] v);
		logic [31:0] w;
		w = $urandom;
		w[2:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RELAY_COUNT_ADDR;
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		relay_cfg = v;
	endtask

	task automatic run_phase(input logic [2:0] cfg, input int n, input bit hold);
		drain();
		write_relay_count(cfg);
		if (hold)
			hold_req = 1'b1;
		repeat (n) send_random();
	endtask

	// Sink: stretches of always ready, random and mostly stalled, plus one long hold.
	initial begin : sink_pattern
		int mode;
		int len;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(posedge clk);
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			len = $urandom_range(4, 30);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed commands with the reset relay count of two.
		send_cmd(OP_ACK, 32'd1, 8'd0, 64'd0);
		send_cmd(OP_ACK, 32'hFFFF_FFFF, 8'hFF, {64{1'b1}});
		send_cmd(OP_ACK, 32'd0, 8'd0, 64'd0);
		send_cmd(OP_RELAY, 32'd0, 8'd1, {48'd0, setting(8'd0, 8'd1)});
		send_cmd(OP_RELAY, 32'd1, 8'd2, {32'd0, setting(8'd1, 8'd1), setting(8'd0, 8'd1)});
		send_cmd(OP_STATE, 32'd2, 8'd0, 64'd0);
		send_cmd(OP_RELAY, 32'd3, 8'd0, {48'd0, setting(8'd0, 8'd0)});
		send_cmd(OP_RELAY, 32'd4, 8'd3, {16'd0, setting(8'd0, 8'd0), setting(8'd1, 8'd0),
			setting(8'd0, 8'd0)});
		// The first setting sticks even though the second one is out of range.
		send_cmd(OP_RELAY, 32'd5, 8'd2, {32'd0, setting(8'd2, 8'd1), setting(8'd1, 8'd0)});
		send_cmd(OP_RELAY, 32'd6, 8'd1, {48'd0, setting(8'd0, 8'd2)});
		send_cmd(OP_RELAY, 32'd7, 8'hFF, {64{1'b1}});
		send_cmd(OP_RELAY, 32'd8, 8'd1, {48'd0, setting(8'd1, 8'hFF)});
		send_cmd(OP_STATE, 32'd9, 8'hFF, {64{1'b1}});
		send_cmd(OP_QUIT, 32'd10, 8'd0, 64'd0);
		send_cmd(3'd4, 32'd11, 8'd0, 64'd0);
		send_cmd(3'd5, 32'd12, 8'd0, 64'd0);
		send_cmd(3'd6, 32'd13, 8'd0, 64'd0);
		send_cmd(OP_MAX, 32'd14, 8'd0, 64'd0);
		send_cmd(OP_RELAY, 32'd16, 8'd1, {48'd0, setting(8'd0, 8'd1)});
		send_cmd(OP_STATE, 32'd15, 8'd0, 64'd0);
		send_cmd(OP_ACK, 32'd6, 8'd0, 64'd0);
		send_cmd(OP_ACK, 32'd5, 8'd0, 64'd0);
		send_cmd(OP_ACK, 32'd8, 8'd0, 64'd0);

		run_phase(3'd4, 30, 1'b1);
		run_phase(3'd1, 15, 1'b0);
		run_phase(3'd0, 12, 1'b0);
		run_phase(3'd7, 20, 1'b0);
		run_phase(3'd3, 15, 1'b0);
		run_phase(3'd2, 15, 1'b0);
		drain();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule

[sequenced_relay_command_handler.f]
sv/rsc_pkg.sv
sv/rsc_lane.sv
sv/rsc_merge.sv
sv/sequenced_relay_command_handler.sv
bench/relay_cmd_checker.sv
bench/sequenced_relay_command_handler_tb.sv
